[design/trtlc_pkg.sv]
// trtlc_pkg: shared types and constants for the two-road traffic light controller
// holds payload structs, mode and color codes, register indexes and reset values
// no dependencies
package trtlc_pkg;

  // lamp colors
  localparam logic [1:0] COLOR_RED   = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_AMBER = 2'd2;

  // operating modes
  localparam logic [2:0] MODE_RUN         = 3'd1;
  localparam logic [2:0] MODE_HOLD        = 3'd2;
  localparam logic [2:0] MODE_RED_BLINK   = 3'd3;
  localparam logic [2:0] MODE_AMBER_BLINK = 3'd4;
  localparam logic [2:0] MODE_GREEN_BLINK = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_RED_SECONDS   = 3'd0;
  localparam logic [2:0] REG_GREEN_SECONDS = 3'd1;
  localparam logic [2:0] REG_AMBER_SECONDS = 3'd2;
  localparam logic [2:0] REG_TICKS_PER_SEC = 3'd3;
  localparam logic [2:0] REG_BLINK_TICKS   = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS    = 3'd5;

  localparam int ADDR_W = 5;

  // register reset values
  localparam logic [6:0]  RST_RED_SECONDS   = 7'd5;
  localparam logic [6:0]  RST_GREEN_SECONDS = 7'd3;
  localparam logic [6:0]  RST_AMBER_SECONDS = 7'd2;
  localparam logic [9:0]  RST_TICKS_PER_SEC = 10'd100;
  localparam logic [9:0]  RST_BLINK_TICKS   = 10'd25;
  localparam logic [15:0] RST_HOLD_TICKS    = 16'd1000;

  typedef struct packed {
    logic       func;
    logic [2:0] new_mode;
  } in_t;

  typedef struct packed {
    logic [1:0] road0_color;
    logic [1:0] road1_color;
    logic       lamps_lit;
    logic [6:0] display0;
    logic [6:0] display1;
    logic [2:0] active_mode;
  } out_t;

endpackage

[design/two_road_traffic_light_controller_unit.sv]
// two_road_traffic_light_controller_unit: top level of the traffic light controller
// state update, output register with skid stage, apb register file
// depends on trtlc_pkg
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+----------------------------------
//   in      | in  | in_valid / in_stall | trtlc_pkg::in_t  (func, new_mode)
//   out     | out | out_valid/out_stall | trtlc_pkg::out_t (lamps, displays)
//   cfg     | in  | psel/penable/pready | six registers, 32-bit data
//
// one item per cycle unless stalled: each beat updates the state when it is taken,
// and its result goes to the output register, or to the skid stage if that is full.
// the output register and a one-entry skid stage decouple the two sides, so a
// new beat is taken while a result waits; in_stall rises only when both hold data.
// rst_n is synchronous; it resets the mode state, buffers and register values.
module two_road_traffic_light_controller_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  trtlc_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output trtlc_pkg::out_t              out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trtlc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import trtlc_pkg::*;

  // configuration registers
  logic [6:0]  red_sec_r, green_sec_r, amber_sec_r;
  logic [9:0]  tps_r, blink_r;
  logic [15:0] hold_r;

  // controller state
  logic [2:0]  mode_r, mode_nxt;
  logic        init_r, init_nxt;
  logic [1:0]  color0_r, color0_nxt, color1_r, color1_nxt;
  logic [6:0]  left0_r, left0_nxt, left1_r, left1_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        lamp_r, lamp_nxt;
  logic [6:0]  shown_r, shown_nxt;

  // output buffers
  logic        out_vld_r, skid_vld_r;
  out_t        out_r, skid_r;
  out_t        res;

  logic        accept, out_take, cfg_wr;
  logic [2:0]  cfg_idx;

  logic        act, init_eff, expired;
  logic [2:0]  mode_eff;
  logic [15:0] timer_dec, timer_base;
  logic [1:0]  blink_color;

  function automatic logic [6:0] dur_of(input logic [1:0] color, input logic [6:0] red,
                                        input logic [6:0] green, input logic [6:0] amber);
    logic [6:0] d;
    case (color)
      COLOR_GREEN: d = green;
      COLOR_AMBER: d = amber;
      default:     d = red;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] next_color(input logic [1:0] color);
    return (color >= COLOR_AMBER) ? COLOR_RED : color + 2'd1;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign out_take = out_vld_r && !out_stall;
  assign in_stall = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // apb
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_RED_SECONDS:   prdata = {25'd0, red_sec_r};
      REG_GREEN_SECONDS: prdata = {25'd0, green_sec_r};
      REG_AMBER_SECONDS: prdata = {25'd0, amber_sec_r};
      REG_TICKS_PER_SEC: prdata = {22'd0, tps_r};
      REG_BLINK_TICKS:   prdata = {22'd0, blink_r};
      REG_HOLD_TICKS:    prdata = {16'd0, hold_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_sec_r   <= RST_RED_SECONDS;
      green_sec_r <= RST_GREEN_SECONDS;
      amber_sec_r <= RST_AMBER_SECONDS;
      tps_r       <= RST_TICKS_PER_SEC;
      blink_r     <= RST_BLINK_TICKS;
      hold_r      <= RST_HOLD_TICKS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RED_SECONDS:   red_sec_r   <= pwdata[6:0];
        REG_GREEN_SECONDS: green_sec_r <= pwdata[6:0];
        REG_AMBER_SECONDS: amber_sec_r <= pwdata[6:0];
        REG_TICKS_PER_SEC: tps_r       <= pwdata[9:0];
        REG_BLINK_TICKS:   blink_r     <= pwdata[9:0];
        REG_HOLD_TICKS:    hold_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign timer_dec = (timer_r != 16'd0) ? timer_r - 16'd1 : 16'd0;

  // work out which mode pass runs this beat, folding the hold end into a run entry
  always_comb begin
    act        = 1'b0;
    mode_eff   = mode_r;
    init_eff   = init_r;
    expired    = 1'b0;
    timer_base = timer_r;
    if (in_data.func) begin
      if (in_data.new_mode >= MODE_RUN && in_data.new_mode <= MODE_GREEN_BLINK) begin
        act      = 1'b1;
        mode_eff = in_data.new_mode;
        init_eff = 1'b0;
      end
    end else begin
      act        = 1'b1;
      timer_base = timer_dec;
      expired    = (timer_dec == 16'd0);
      if (mode_r == MODE_HOLD && init_r && expired) begin
        mode_eff = MODE_RUN;
        init_eff = 1'b0;
      end
    end
  end

  always_comb begin
    if (mode_eff == MODE_RED_BLINK) blink_color = COLOR_RED;
    else if (mode_eff == MODE_AMBER_BLINK) blink_color = COLOR_AMBER;
    else blink_color = COLOR_GREEN;
  end

  always_comb begin
    mode_nxt   = mode_r;
    init_nxt   = init_r;
    color0_nxt = color0_r;
    color1_nxt = color1_r;
    left0_nxt  = left0_r;
    left1_nxt  = left1_r;
    timer_nxt  = timer_r;
    lamp_nxt   = lamp_r;
    shown_nxt  = shown_r;
    if (act) begin
      mode_nxt  = mode_eff;
      init_nxt  = init_eff;
      timer_nxt = timer_base;
      unique case (mode_eff) inside
        MODE_RUN: begin
          if (!init_eff) begin
            color0_nxt = COLOR_RED;
            color1_nxt = COLOR_GREEN;
            left0_nxt  = red_sec_r;
            left1_nxt  = green_sec_r;
            init_nxt   = 1'b1;
            lamp_nxt   = 1'b1;
            timer_nxt  = {6'd0, tps_r};
          end else if (expired) begin
            if (left0_r <= 7'd1) begin
              color0_nxt = next_color(color0_r);
              left0_nxt  = dur_of(next_color(color0_r), red_sec_r, green_sec_r, amber_sec_r);
            end else begin
              left0_nxt = left0_r - 7'd1;
            end
            if (left1_r <= 7'd1) begin
              color1_nxt = next_color(color1_r);
              left1_nxt  = dur_of(next_color(color1_r), red_sec_r, green_sec_r, amber_sec_r);
            end else begin
              left1_nxt = left1_r - 7'd1;
            end
            lamp_nxt  = 1'b1;
            timer_nxt = {6'd0, tps_r};
          end
        end
        MODE_HOLD: begin
          if (!init_eff) begin
            color0_nxt = COLOR_RED;
            color1_nxt = COLOR_GREEN;
            init_nxt   = 1'b1;
            timer_nxt  = hold_r;
          end
          lamp_nxt = 1'b1;
        end
        MODE_RED_BLINK, MODE_AMBER_BLINK, MODE_GREEN_BLINK: begin
          if (!init_eff) begin
            color0_nxt = blink_color;
            color1_nxt = blink_color;
            shown_nxt  = dur_of(blink_color, red_sec_r, green_sec_r, amber_sec_r);
            init_nxt   = 1'b1;
            lamp_nxt   = 1'b1;
            timer_nxt  = {6'd0, blink_r};
          end else if (expired) begin
            lamp_nxt  = !lamp_r;
            timer_nxt = {6'd0, blink_r};
          end
          left0_nxt = shown_nxt;
          left1_nxt = {4'd0, mode_eff};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.road0_color = color0_nxt;
    res.road1_color = color1_nxt;
    res.lamps_lit   = lamp_nxt;
    res.display0    = left0_nxt;
    res.display1    = left1_nxt;
    res.active_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RUN;
      init_r   <= 1'b0;
      color0_r <= COLOR_RED;
      color1_r <= COLOR_GREEN;
      left0_r  <= 7'd0;
      left1_r  <= 7'd0;
      timer_r  <= 16'd0;
      lamp_r   <= 1'b1;
      shown_r  <= 7'd0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      init_r   <= init_nxt;
      color0_r <= color0_nxt;
      color1_r <= color1_nxt;
      left0_r  <= left0_nxt;
      left1_r  <= left1_nxt;
      timer_r  <= timer_nxt;
      lamp_r   <= lamp_nxt;
      shown_r  <= shown_nxt;
    end
  end

  // output register plus skid stage; skid is empty whenever a beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (accept) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r  <= skid_vld_r;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_vld_r || out_take) out_r <= res;
      else skid_r <= res;
    end else if (out_take && skid_vld_r) begin
      out_r <= skid_r;
    end
  end

  // skid only fills behind a full output register
  assert property (@(posedge clk) disable iff (!rst_n) skid_vld_r |-> out_vld_r)
    else $error("skid holds data while output register is empty");

  assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_vld_r)
    else $error("accepted beat produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.active_mode >= MODE_RUN && out_r.active_mode <= MODE_GREEN_BLINK))
    else $error("result carries an unknown mode");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.active_mode == MODE_AMBER_BLINK) |->
      (out_r.road0_color == COLOR_AMBER && out_r.road1_color == COLOR_AMBER))
    else $error("amber blink mode shows a non-amber lamp");

endmodule
